>>> sv/vfc_pkg.sv
`timescale 1ns / 1ps
package vfc_pkg;

	localparam int REG_ADDR_W = 4;

	localparam logic [1:0] REG_QUAD  = 2'd0;
	localparam logic [1:0] REG_LIN   = 2'd1;
	localparam logic [1:0] REG_CONST = 2'd2;
	localparam logic [1:0] REG_STEP  = 2'd3;

	localparam logic [31:0] RST_QUAD  = 32'd8388608;
	localparam logic [31:0] RST_LIN   = 32'd3355443;
	localparam logic [31:0] RST_CONST = 32'd16777;
	localparam logic [31:0] RST_STEP  = 32'd279620;

endpackage

>>> sv/velocity_friction_cell.sv
`timescale 1ns / 1ps
// channel | dir | handshake          | payload
// s_*     | in  | s_tvalid/s_tready  | s_tdata: vel_x, vel_y
// m_*     | out | m_tvalid/m_tready  | m_tdata: new_vel_x, new_vel_y
// apb     | in  | psel/penable       | paddr, pwdata, prdata
//
// One transaction per cycle while m_tready accepts output; the pipeline depth is
// set by the bit-per-stage square root and the bit-per-stage divider.
// arst_n clears all valid bits and loads the coefficient registers with their reset values.
// Each stage moves when it is empty or the next one moves; bubbles collapse.
// Coefficient products are registered and follow a register write in the cycle after it.
module velocity_friction_cell
	import vfc_pkg::*;
#(
	parameter int FRAC_BITS   = 24,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0] s_tdata, // vel_x, vel_y
	output logic m_tvalid,
	input  logic m_tready,
	output logic [((2*VALUE_WIDTH+7)/8)*8-1:0] m_tdata, // new_vel_x, new_vel_y
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int W    = VALUE_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int TDW  = ((2*W+7)/8)*8;
	localparam int SW   = 2*W;
	localparam int CW   = 64 - F;
	localparam int QW   = SW - F;
	localparam int H    = QW/2;
	localparam int N0   = (CW+QW > CW+W) ? CW+QW : CW+W;
	localparam int N1   = (N0 > 64) ? N0 : 64;
	localparam int NW   = N1 + 2;
	localparam int DW   = W + 1;
	localparam int RW   = DW + F;
	localparam int XW   = (NW > RW) ? NW : RW;
	localparam int KW   = F + 1;
	localparam int PW   = W + KW + 1;
	localparam int EPS0 = ((1 << F) + 5000) / 10000;
	localparam int EPS  = (EPS0 > 0) ? EPS0 : 1;
	localparam int P_SQ = 3;
	localparam int P_M1 = 3 + W;
	localparam int P_M2 = 4 + W;
	localparam int P_D0 = 5 + W;
	localparam int P_DV = 6 + W;
	localparam int P_O1 = 6 + W + F;
	localparam int P_O2 = 7 + W + F;
	localparam int NS   = 8 + W + F;
	localparam logic [KW-1:0] ONE = KW'(1) << F;

	typedef struct packed {
		logic signed [W-1:0] vx;
		logic signed [W-1:0] vy;
		logic [SW:0]         rem;
		logic [W-1:0]        root;
		logic [QW-1:0]       sqf;
	} sqrt_t;

	typedef struct packed {
		logic signed [W-1:0] vx;
		logic signed [W-1:0] vy;
		logic [RW-1:0]       rem;
		logic [DW-1:0]       den;
		logic [KW-1:0]       k;
		logic                one;
	} div_t;

	// configuration
	logic [31:0] quad_q, lin_q, const_q, step_q;
	logic [CW-1:0] ca_q, cb_q, cc_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_q  <= RST_QUAD;
			lin_q   <= RST_LIN;
			const_q <= RST_CONST;
			step_q  <= RST_STEP;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_QUAD:  quad_q  <= pwdata;
				REG_LIN:   lin_q   <= pwdata;
				REG_CONST: const_q <= pwdata;
				REG_STEP:  step_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_QUAD:  prdata = quad_q;
			REG_LIN:   prdata = lin_q;
			REG_CONST: prdata = const_q;
			REG_STEP:  prdata = step_q;
			default:   prdata = '0;
		endcase
	end

	logic [63:0] pqa, pqb, pqc;
	assign pqa = 64'(quad_q) * 64'(step_q);
	assign pqb = 64'(lin_q) * 64'(step_q);
	assign pqc = 64'(const_q) * 64'(step_q);

	always_ff @(posedge clk) begin
		ca_q <= pqa[63:F];
		cb_q <= pqb[63:F];
		cc_q <= pqc[63:F];
	end

	// stage flow control
	logic [NS-1:0] v_q;
	logic [NS-1:0] en;
	logic [NS-1:0] vin;

	always_comb begin
		en[NS-1] = !v_q[NS-1] || m_tready;
		for (int i = NS-2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	assign vin = {v_q[NS-2:0], s_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (en[i]) v_q[i] <= vin[i];
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = v_q[NS-1];

	// input, squares, sum
	logic signed [W-1:0] vx_s1, vy_s1, vx_s2, vy_s2, vx_s3, vy_s3;
	logic [SW-1:0] sqx_s2, sqy_s2, sq_s3;
	logic signed [SW-1:0] px, py;

	assign px = vx_s1 * vx_s1;
	assign py = vy_s1 * vy_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			vx_s1 <= s_tdata[W-1:0];
			vy_s1 <= s_tdata[SW-1:W];
		end
		if (en[1]) begin
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			sqx_s2 <= px;
			sqy_s2 <= py;
		end
		if (en[2]) begin
			vx_s3 <= vx_s2;
			vy_s3 <= vy_s2;
			sq_s3 <= sqx_s2 + sqy_s2;
		end
	end

	// square root, one result bit per stage
	sqrt_t sr_s [W];

	for (genvar j = 0; j < W; j++) begin : g_sqrt
		sqrt_t src, nxt;
		logic [SW:0] t;
		if (j == 0) begin : g_first
			assign src.vx   = vx_s3;
			assign src.vy   = vy_s3;
			assign src.rem  = {1'b0, sq_s3};
			assign src.root = '0;
			assign src.sqf  = sq_s3[SW-1:F];
		end else begin : g_next
			assign src = sr_s[j-1];
		end
		assign t = ((SW+1)'(src.root) << (W-j)) + ((SW+1)'(1) << (2*(W-1-j)));
		always_comb begin
			nxt = src;
			if (src.rem >= t) begin
				nxt.rem  = src.rem - t;
				nxt.root = src.root | (W'(1) << (W-1-j));
			end
		end
		always_ff @(posedge clk) begin
			if (en[P_SQ+j]) sr_s[j] <= nxt;
		end
	end

	// numerator terms
	sqrt_t sl;
	logic [CW+H-1:0]      pal_m1;
	logic [CW+QW-H-1:0]   pah_m1;
	logic [CW+W-1:0]      pb_m1;
	logic [W-1:0]         len_m1;
	logic signed [W-1:0]  vx_m1, vy_m1, vx_m2, vy_m2;
	logic [NW-1:0]        num_m2;
	logic [DW-1:0]        den_m2;

	assign sl = sr_s[W-1];

	always_ff @(posedge clk) begin
		if (en[P_M1]) begin
			vx_m1  <= sl.vx;
			vy_m1  <= sl.vy;
			len_m1 <= sl.root;
			pal_m1 <= (CW+H)'(ca_q) * (CW+H)'(sl.sqf[H-1:0]);
			pah_m1 <= (CW+QW-H)'(ca_q) * (CW+QW-H)'(sl.sqf[QW-1:H]);
			pb_m1  <= (CW+W)'(cb_q) * (CW+W)'(sl.root);
		end
		if (en[P_M2]) begin
			vx_m2  <= vx_m1;
			vy_m2  <= vy_m1;
			num_m2 <= NW'(pal_m1) + (NW'(pah_m1) << H) + NW'(pb_m1) + (NW'(cc_q) << F);
			den_m2 <= DW'(len_m1) + DW'(EPS);
		end
	end

	// division, clamp test then one quotient bit per stage
	div_t dv_s [F+1];

	always_ff @(posedge clk) begin
		if (en[P_D0]) begin
			dv_s[0].vx  <= vx_m2;
			dv_s[0].vy  <= vy_m2;
			dv_s[0].rem <= num_m2[RW-1:0];
			dv_s[0].den <= den_m2;
			dv_s[0].one <= XW'(num_m2) >= (XW'(den_m2) << F);
			dv_s[0].k   <= '0;
		end
	end

	for (genvar j = 0; j < F; j++) begin : g_div
		logic [RW-1:0] t;
		div_t nxt;
		assign t = RW'(dv_s[j].den) << (F-1-j);
		always_comb begin
			nxt = dv_s[j];
			if (!dv_s[j].one && dv_s[j].rem >= t) begin
				nxt.rem = dv_s[j].rem - t;
				nxt.k   = dv_s[j].k | (KW'(1) << (F-1-j));
			end
		end
		always_ff @(posedge clk) begin
			if (en[P_DV+j]) dv_s[j+1] <= nxt;
		end
	end

	// rotate and damp
	div_t dl;
	logic [KW-1:0] kf, mf;
	logic signed [PW-1:0] p0_o1, p1_o1, p2_o1, p3_o1;
	logic [KW-1:0] k_o1;

	assign dl = dv_s[F];
	assign kf = dl.one ? ONE : dl.k;
	assign mf = ONE - kf;

	always_ff @(posedge clk) begin
		if (en[P_O1]) begin
			k_o1  <= kf;
			p0_o1 <= PW'(dl.vy) * PW'($signed({1'b0, kf}));
			p1_o1 <= PW'(dl.vx) * PW'($signed({1'b0, mf}));
			p2_o1 <= PW'(dl.vx) * PW'($signed({1'b0, kf}));
			p3_o1 <= PW'(dl.vy) * PW'($signed({1'b0, mf}));
		end
	end

	logic signed [PW:0] nx, ny, nxs, nys;
	logic signed [W-1:0] ox, oy;
	localparam logic signed [PW:0] VMAX = (PW+1)'((W'(1) << (W-1)) - W'(1));
	localparam logic signed [PW:0] VMIN = -VMAX - (PW+1)'(1);

	assign nx  = (PW+1)'(p1_o1) - (PW+1)'(p0_o1);
	assign ny  = (PW+1)'(p2_o1) + (PW+1)'(p3_o1);
	assign nxs = nx >>> F;
	assign nys = ny >>> F;
	assign ox  = (nxs > VMAX) ? VMAX[W-1:0] : (nxs < VMIN) ? VMIN[W-1:0] : nxs[W-1:0];
	assign oy  = (nys > VMAX) ? VMAX[W-1:0] : (nys < VMIN) ? VMIN[W-1:0] : nys[W-1:0];

	logic [SW-1:0] out_o2;

	always_ff @(posedge clk) begin
		if (en[P_O2]) out_o2 <= {oy, ox};
	end

	assign m_tdata = TDW'(out_o2);

	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&v_q))
		else $error("input stalled with an empty stage");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[P_O1] |-> (k_o1 <= ONE))
		else $error("drag above one");

	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[P_SQ+W-1] |-> (sl.rem <= ((SW+1)'(sl.root) << 1)))
		else $error("square root remainder too large");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[P_DV+F-1] && !dl.one) |-> (dl.rem < RW'(dl.den)))
		else $error("division remainder too large");

endmodule
